// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the zone min/max summariser.
// No dependencies; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ----- rtl/zmm_pkg.sv -----
// Package for the zone min/max summariser: word types, type codes, register indexes
// and the per-type helper functions (masks, extremes, NaN test, ordering key).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package zmm_pkg;

    // Largest zone size exponent handled by default
    localparam int ZMM_MAX_ZONE_LOG2 = 16;

    // Configuration port geometry and register indexes
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_TYPE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZONE_LOG2  = 4'd1;

    // Reset values of the configuration registers
    localparam logic [4:0] ZONE_LOG2_RESET = 5'd10;

    typedef enum logic [2:0] {
        VT_INT8    = 3'd0,
        VT_INT16   = 3'd1,
        VT_INT32   = 3'd2,
        VT_INT64   = 3'd3,
        VT_UINT64  = 3'd4,
        VT_FLOAT32 = 3'd5,
        VT_FLOAT64 = 3'd6
    } vtype_t;

    typedef struct packed {
        logic [63:0] value_bits;
        logic        column_end;
    } item_word_t;

    typedef struct packed {
        logic [31:0] zone_number;
        logic [63:0] zone_low;
        logic [63:0] zone_high;
        logic [63:0] column_low;
        logic [63:0] column_high;
        logic        final_zone;
    } result_word_t;

    // Bits of the raw word that the type uses
    function automatic logic [63:0] type_mask(vtype_t t);
        logic [63:0] m;
        unique case (t)
            VT_INT8:               m = 64'h0000_0000_0000_00FF;
            VT_INT16:              m = 64'h0000_0000_0000_FFFF;
            VT_INT32, VT_FLOAT32:  m = 64'h0000_0000_FFFF_FFFF;
            default:               m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // Largest finite value of the type, as raw bits
    function automatic logic [63:0] type_max(vtype_t t);
        logic [63:0] r;
        unique case (t)
            VT_INT8:    r = 64'h0000_0000_0000_007F;
            VT_INT16:   r = 64'h0000_0000_0000_7FFF;
            VT_INT32:   r = 64'h0000_0000_7FFF_FFFF;
            VT_UINT64:  r = 64'hFFFF_FFFF_FFFF_FFFF;
            VT_FLOAT32: r = 64'h0000_0000_7F7F_FFFF;
            VT_FLOAT64: r = 64'h7FEF_FFFF_FFFF_FFFF;
            default:    r = 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
        return r;
    endfunction

    // Smallest finite value of the type, as raw bits
    function automatic logic [63:0] type_min(vtype_t t);
        logic [63:0] r;
        unique case (t)
            VT_INT8:    r = 64'h0000_0000_0000_0080;
            VT_INT16:   r = 64'h0000_0000_0000_8000;
            VT_INT32:   r = 64'h0000_0000_8000_0000;
            VT_UINT64:  r = 64'h0000_0000_0000_0000;
            VT_FLOAT32: r = 64'h0000_0000_FF7F_FFFF;
            VT_FLOAT64: r = 64'hFFEF_FFFF_FFFF_FFFF;
            default:    r = 64'h8000_0000_0000_0000;
        endcase
        return r;
    endfunction

    // NaN test for the floating types; integers never are NaN
    function automatic logic is_nan(vtype_t t, logic [63:0] v);
        logic r;
        unique case (t)
            VT_FLOAT32: r = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
            VT_FLOAT64: r = (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    // Unsigned key whose order matches the value order of the type
    function automatic logic [63:0] order_key(vtype_t t, logic [63:0] v);
        logic [63:0] m;
        logic [63:0] sign;
        logic [63:0] x;
        logic [63:0] k;
        m = type_mask(t);
        x = v & m;
        unique case (t)
            VT_UINT64: k = x;
            VT_FLOAT32, VT_FLOAT64:
            begin
                sign = (t == VT_FLOAT32) ? 64'h0000_0000_8000_0000
                                         : 64'h8000_0000_0000_0000;
                // fold -0 onto +0
                if ((x & (sign - 64'd1)) == 64'd0)
                begin
                    x = 64'd0;
                end
                k = ((x & sign) != 64'd0) ? (~x & m) : (x | sign);
            end
            default:
            begin
                sign = (m >> 1) + 64'd1;
                k = (x ^ sign) & m;
            end
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/zmm_result_queue.sv -----
// Two-word result queue between the summariser datapath and the result channel.
// Depends on zmm_pkg for the result word type.
`timescale 1ns / 1ps
`default_nettype none

module zmm_result_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire zmm_pkg::result_word_t push_word,
    output logic                       full,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output zmm_pkg::result_word_t      result
);
    import zmm_pkg::*;

    logic         head_valid_reg;
    logic         head_valid_next;
    logic         tail_valid_reg;
    logic         tail_valid_next;
    result_word_t head_reg;
    result_word_t head_next;
    result_word_t tail_reg;
    result_word_t tail_next;
    logic         pop;

    assign pop          = head_valid_reg && result_ready;
    assign full         = tail_valid_reg;
    assign result_valid = head_valid_reg;
    assign result       = head_reg;

    // Move the tail word into the head on a pop, then drop a pushed word into the first free slot
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;
        if (pop)
        begin
            head_next       = tail_reg;
            head_valid_next = tail_valid_reg;
            tail_valid_next = 1'b0;
        end
        if (push)
        begin
            if (!head_valid_next)
            begin
                head_next       = push_word;
                head_valid_next = 1'b1;
            end
            else
            begin
                tail_next       = push_word;
                tail_valid_next = 1'b1;
            end
        end
    end

    // Hold the valid flags under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    // Payload words
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire

// ----- rtl/zone_min_max_summarizer.sv -----
// Top level of the zone min/max summariser: running extremes, zone tracking, config.
// Depends on zmm_pkg and zmm_result_queue.
`timescale 1ns / 1ps
`default_nettype none

// Zone min/max summariser. One column value is taken per cycle while item_ready
// is high, as a raw 64-bit word, and read as the type held in register 0
// (int8/16/32/64, uint64, float32, float64; code 7 reads as int64). Each value is
// compared against the zone and column extremes in the same cycle it is accepted;
// a zone closes after 2^zone_size_log2 values (register 1, saturated at
// MAX_ZONE_LOG2) or at a word marked column_end, and its summary word is then
// written into the result queue. Results wait in a two-word queue, so item_ready
// stays high while fewer than two results are waiting; with the result side ready
// the block sustains one item per cycle. NaNs count towards the zone length but
// never become an extreme. cfg_ready is always high; a configuration write (to
// register 0 or 1; other indexes are ignored) restarts the column and must be
// issued only while the block is idle. No clearing pass is needed after reset.
module zone_min_max_summarizer #(
    parameter int MAX_ZONE_LOG2 = zmm_pkg::ZMM_MAX_ZONE_LOG2
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_ready,
    input  wire zmm_pkg::item_word_t              item,
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output zmm_pkg::result_word_t                 result,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [zmm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [zmm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import zmm_pkg::*;

    localparam int POS_W = MAX_ZONE_LOG2;

    // Configuration
    vtype_t           value_type_reg;
    vtype_t           value_type_next;
    logic [4:0]       zone_log2_reg;
    logic [4:0]       zone_log2_next;
    logic             cfg_fire;
    logic             cfg_hit;

    // Running state
    logic [63:0]      zone_min_reg;
    logic [63:0]      zone_min_next;
    logic [63:0]      zone_max_reg;
    logic [63:0]      zone_max_next;
    logic [63:0]      col_min_reg;
    logic [63:0]      col_min_next;
    logic [63:0]      col_max_reg;
    logic [63:0]      col_max_next;
    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] position_next;
    logic [31:0]      zone_count_reg;
    logic [31:0]      zone_count_next;

    // Datapath
    logic             item_fire;
    logic             queue_full;
    logic [4:0]       zone_lg;
    logic [POS_W-1:0] zone_mask;
    logic [63:0]      value;
    logic [63:0]      value_key;
    logic             value_nan;
    logic [63:0]      upd_zone_min;
    logic [63:0]      upd_zone_max;
    logic [63:0]      upd_col_min;
    logic [63:0]      upd_col_max;
    logic             zone_done;
    logic             emit;
    result_word_t     summary;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign cfg_hit    = cfg_fire && (cfg_index == CFG_VALUE_TYPE || cfg_index == CFG_ZONE_LOG2);
    assign item_ready = !queue_full;
    assign item_fire  = item_valid && item_ready;

    // Saturate the zone exponent and expand it to a position mask
    always_comb
    begin
        zone_lg = (zone_log2_reg > 5'(MAX_ZONE_LOG2)) ? 5'(MAX_ZONE_LOG2) : zone_log2_reg;
        for (int i = 0; i < POS_W; i++)
        begin
            zone_mask[i] = (5'(i) < zone_lg);
        end
    end

    // Compare the new value against all four extremes
    always_comb
    begin
        value        = item.value_bits & type_mask(value_type_reg);
        value_nan    = is_nan(value_type_reg, value);
        value_key    = order_key(value_type_reg, value);
        upd_zone_min = zone_min_reg;
        upd_zone_max = zone_max_reg;
        upd_col_min  = col_min_reg;
        upd_col_max  = col_max_reg;
        if (!value_nan)
        begin
            if (value_key < order_key(value_type_reg, zone_min_reg))
            begin
                upd_zone_min = value;
            end
            if (value_key > order_key(value_type_reg, zone_max_reg))
            begin
                upd_zone_max = value;
            end
            if (value_key < order_key(value_type_reg, col_min_reg))
            begin
                upd_col_min = value;
            end
            if (value_key > order_key(value_type_reg, col_max_reg))
            begin
                upd_col_max = value;
            end
        end
        zone_done = (position_reg == zone_mask) || item.column_end;
        emit      = item_fire && zone_done;

        summary.zone_number = zone_count_reg;
        summary.zone_low    = upd_zone_min;
        summary.zone_high   = upd_zone_max;
        summary.column_low  = upd_col_min;
        summary.column_high = upd_col_max;
        summary.final_zone  = item.column_end;
    end

    // Next state: a write to register 0 or 1 restarts the column, otherwise advance on an item
    always_comb
    begin
        value_type_next = value_type_reg;
        zone_log2_next  = zone_log2_reg;
        zone_min_next   = zone_min_reg;
        zone_max_next   = zone_max_reg;
        col_min_next    = col_min_reg;
        col_max_next    = col_max_reg;
        position_next   = position_reg;
        zone_count_next = zone_count_reg;
        if (cfg_hit)
        begin
            if (cfg_index == CFG_VALUE_TYPE)
            begin
                value_type_next = (cfg_data[2:0] > 3'(VT_FLOAT64)) ? VT_INT64
                                                                   : vtype_t'(cfg_data[2:0]);
            end
            else
            begin
                zone_log2_next = cfg_data;
            end
            zone_min_next   = type_max(value_type_next);
            zone_max_next   = type_min(value_type_next);
            col_min_next    = type_max(value_type_next);
            col_max_next    = type_min(value_type_next);
            position_next   = '0;
            zone_count_next = '0;
        end
        else if (item_fire)
        begin
            zone_min_next = upd_zone_min;
            zone_max_next = upd_zone_max;
            col_min_next  = upd_col_min;
            col_max_next  = upd_col_max;
            if (!zone_done)
            begin
                position_next = (position_reg + POS_W'(1)) & zone_mask;
            end
            else
            begin
                zone_min_next = type_max(value_type_reg);
                zone_max_next = type_min(value_type_reg);
                position_next = '0;
                if (item.column_end)
                begin
                    col_min_next    = type_max(value_type_reg);
                    col_max_next    = type_min(value_type_reg);
                    zone_count_next = '0;
                end
                else
                begin
                    zone_count_next = zone_count_reg + 32'd1;
                end
            end
        end
    end

    // State registers; reset state matches an int64 column with zones of 1024
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_type_reg <= VT_INT64;
            zone_log2_reg  <= ZONE_LOG2_RESET;
            zone_min_reg   <= type_max(VT_INT64);
            zone_max_reg   <= type_min(VT_INT64);
            col_min_reg    <= type_max(VT_INT64);
            col_max_reg    <= type_min(VT_INT64);
            position_reg   <= '0;
            zone_count_reg <= '0;
        end
        else
        begin
            value_type_reg <= value_type_next;
            zone_log2_reg  <= zone_log2_next;
            zone_min_reg   <= zone_min_next;
            zone_max_reg   <= zone_max_next;
            col_min_reg    <= col_min_next;
            col_max_reg    <= col_max_next;
            position_reg   <= position_next;
            zone_count_reg <= zone_count_next;
        end
    end

    // Queue finished zone summaries for the result channel
    zmm_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (emit),
        .push_word    (summary),
        .full         (queue_full),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- rtl/zmm_checker.sv -----
// Port-level checker for the zone min/max summariser, bound to the top level.
// Depends on zmm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module zmm_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             item_valid,
    input wire logic                             item_ready,
    input wire zmm_pkg::item_word_t              item,
    input wire logic                             result_valid,
    input wire logic                             result_ready,
    input wire zmm_pkg::result_word_t            result,
    input wire logic                             cfg_valid,
    input wire logic                             cfg_ready
);
    import zmm_pkg::*;

    logic item_fire;
    logic result_stall;
    logic end_to_empty;

    assign item_fire    = item_valid && item_ready;
    assign result_stall = result_valid && !result_ready;
    assign end_to_empty = item_fire && item.column_end && !result_valid;

    // A stalled result word holds
    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_stall, result_valid && $stable(result))

    // Input back-pressure only when a result is already waiting
    `ASSERT_IMPLY(a_stall_needs_result, clk, rst_n, !item_ready, result_valid)

    // Configuration writes are never stalled
    `ASSERT_IMPLY(a_cfg_always_ready, clk, rst_n, cfg_valid, cfg_ready)

    // A column end into an empty result side shows as a final word next cycle
    `ASSERT_NEXT(a_column_end_final, clk, rst_n, end_to_empty, result_valid && result.final_zone)

endmodule

bind zone_min_max_summarizer zmm_checker u_zmm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);

`default_nettype wire

// ----- bench/tb_zone_min_max_summarizer.sv -----
// Self-checking bench for the zone min/max summariser: directed and random value streams,
// an in-bench zone summary predictor and per-field checks of every summary word.
// Depends on zmm_pkg and the zone_min_max_summarizer RTL.
`timescale 1ns / 1ps

module tb_zone_min_max_summarizer;
    import zmm_pkg::*;

    localparam int HALF_PERIOD_NS = 4;
    localparam int RESET_CYCLES = 6;
    localparam int IDLE_PERCENT = 24;
    localparam int RANDOM_ITEMS = 1650;
    localparam int LONG_RUN_ITEMS = 200;
    localparam int READY_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [2:0] UNDEFINED_TYPE_CODE = 3'd7;
    localparam int FIRST_UNUSED_INDEX = CFG_ZONE_LOG2 + 1;
    localparam int LAST_INDEX = (1 << CFG_INDEX_W) - 1;

    // Predicts the summary words and checks the ones the block emits
    class zone_summary_predictor;
        logic [2:0]   type_code;
        logic [4:0]   zone_log2;
        logic [63:0]  zone_low;
        logic [63:0]  zone_high;
        logic [63:0]  column_low;
        logic [63:0]  column_high;
        int unsigned  position;
        logic [31:0]  zone_count;
        result_word_t pending_summaries[$];
        int           mismatches;

        function new();
            type_code = VT_INT64;
            zone_log2 = ZONE_LOG2_RESET;
            mismatches = 0;
            restart_column();
        endfunction

        // Undefined code reads as int64
        function vtype_t kind();
            return (type_code == UNDEFINED_TYPE_CODE) ? VT_INT64 : vtype_t'(type_code);
        endfunction

        static function logic [63:0] width_mask(vtype_t t);
            case (t)
                VT_INT8:    return 64'h0000_0000_0000_00FF;
                VT_INT16:   return 64'h0000_0000_0000_FFFF;
                VT_INT32:   return 64'h0000_0000_FFFF_FFFF;
                VT_FLOAT32: return 64'h0000_0000_FFFF_FFFF;
                default:    return 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
        endfunction

        static function logic [63:0] top_value(vtype_t t);
            case (t)
                VT_INT8:    return 64'h7F;
                VT_INT16:   return 64'h7FFF;
                VT_INT32:   return 64'h7FFF_FFFF;
                VT_UINT64:  return 64'hFFFF_FFFF_FFFF_FFFF;
                VT_FLOAT32: return 64'h7F7F_FFFF;
                VT_FLOAT64: return 64'h7FEF_FFFF_FFFF_FFFF;
                default:    return 64'h7FFF_FFFF_FFFF_FFFF;
            endcase
        endfunction

        static function logic [63:0] bottom_value(vtype_t t);
            case (t)
                VT_INT8:    return 64'h80;
                VT_INT16:   return 64'h8000;
                VT_INT32:   return 64'h8000_0000;
                VT_UINT64:  return 64'h0;
                VT_FLOAT32: return 64'hFF7F_FFFF;
                VT_FLOAT64: return 64'hFFEF_FFFF_FFFF_FFFF;
                default:    return 64'h8000_0000_0000_0000;
            endcase
        endfunction

        static function logic not_a_number(vtype_t t, logic [63:0] v);
            case (t)
                VT_FLOAT32: return (&v[30:23]) && (|v[22:0]);
                VT_FLOAT64: return (&v[62:52]) && (|v[51:0]);
                default:    return 1'b0;
            endcase
        endfunction

        // Map a value onto an unsigned rank with the same ordering
        static function logic [63:0] rank(vtype_t t, logic [63:0] v);
            logic [63:0] x;
            logic [63:0] r;
            x = v & width_mask(t);
            case (t)
                VT_UINT64: r = x;
                VT_FLOAT32:
                begin
                    // both zeros share the rank of +0
                    if (x[30:0] == 31'd0)
                        r = 64'h8000_0000;
                    else if (x[31])
                        r = {32'd0, ~x[31:0]};
                    else
                        r = {32'd0, 1'b1, x[30:0]};
                end
                VT_FLOAT64:
                begin
                    if (x[62:0] == 63'd0)
                        r = {1'b1, 63'd0};
                    else if (x[63])
                        r = ~x;
                    else
                        r = {1'b1, x[62:0]};
                end
                default: r = x ^ (width_mask(t) ^ (width_mask(t) >> 1));
            endcase
            return r;
        endfunction

        function void restart_zone();
            zone_low = top_value(kind());
            zone_high = bottom_value(kind());
            position = 0;
        endfunction

        function void restart_column();
            column_low = top_value(kind());
            column_high = bottom_value(kind());
            zone_count = '0;
            restart_zone();
        endfunction

        // Any write to a known register starts a new column
        function void write_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_VALUE_TYPE:
                begin
                    type_code = data[2:0];
                    restart_column();
                end
                CFG_ZONE_LOG2:
                begin
                    zone_log2 = data;
                    restart_column();
                end
                default: ;
            endcase
        endfunction

        // Fold one accepted word into the extremes and queue any finished zone
        function void note_value(item_word_t w);
            vtype_t       t;
            logic [63:0]  v;
            logic [63:0]  k;
            int unsigned  lg;
            int unsigned  zone_mask;
            result_word_t summary;
            t = kind();
            v = w.value_bits & width_mask(t);
            if (!not_a_number(t, v))
            begin
                k = rank(t, v);
                if (k < rank(t, column_low))
                    column_low = v;
                if (k > rank(t, column_high))
                    column_high = v;
                if (k < rank(t, zone_low))
                    zone_low = v;
                if (k > rank(t, zone_high))
                    zone_high = v;
            end
            lg = (zone_log2 > ZMM_MAX_ZONE_LOG2) ? ZMM_MAX_ZONE_LOG2 : zone_log2;
            zone_mask = (32'd1 << lg) - 1;
            if (((position & zone_mask) != zone_mask) && !w.column_end)
            begin
                position = (position + 1) & zone_mask;
                return;
            end
            summary.zone_number = zone_count;
            summary.zone_low = zone_low;
            summary.zone_high = zone_high;
            summary.column_low = column_low;
            summary.column_high = column_high;
            summary.final_zone = w.column_end;
            pending_summaries.push_back(summary);
            if (w.column_end)
                restart_column();
            else
            begin
                zone_count = zone_count + 1;
                restart_zone();
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task compare_field(logic [31:0] zone, string name, logic [63:0] got,
                           logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("zone %0d %s: got %h, want %h",
                                          zone, name, got, want));
        endtask

        // Check one emitted summary word against the oldest prediction
        task check_summary(result_word_t got);
            result_word_t want;
            if (pending_summaries.size() == 0)
            begin
                report_mismatch($sformatf("summary word for zone %0d with none outstanding",
                                          got.zone_number));
                return;
            end
            want = pending_summaries.pop_front();
            compare_field(want.zone_number, "zone_number", got.zone_number, want.zone_number);
            compare_field(want.zone_number, "zone_low", got.zone_low, want.zone_low);
            compare_field(want.zone_number, "zone_high", got.zone_high, want.zone_high);
            compare_field(want.zone_number, "column_low", got.column_low, want.column_low);
            compare_field(want.zone_number, "column_high", got.column_high, want.column_high);
            compare_field(want.zone_number, "final_zone", got.final_zone, want.final_zone);
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_ready;
    item_word_t             item = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_word_t           result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int idle_pct = IDLE_PERCENT;
    int ready_hold_left = 0;
    zone_summary_predictor predictor = new();

    zone_min_max_summarizer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 8 ns clock
    always #HALF_PERIOD_NS clk = ~clk;

    // Drive result_ready: a long hold when requested, else random stalls
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (ready_hold_left > 0)
            begin
                result_ready = 1'b0;
                ready_hold_left--;
            end
            else
                result_ready = ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // Check every summary word taken at a rising edge
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            predictor.check_summary(result);
    end

    // End the run when nothing moves for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("** zone_min_max_summarizer: FAILED **");
        $finish;
    end

    // Offer one value word, with random idle cycles ahead of it
    task automatic send_value(logic [63:0] bits, logic last);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        item.value_bits = bits;
        item.column_end = last;
        do
            @(posedge clk);
        while (!item_ready);
        predictor.note_value(item);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] index,
                                  logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        predictor.write_register(index, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold the input until every summary has come and the pipeline is empty
    task automatic drain();
        @(negedge clk);
        item_valid = 1'b0;
        while (predictor.pending_summaries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random value with a bias towards extremes, zeros, infinities and NaNs
    function automatic logic [63:0] random_value(vtype_t t);
        logic [63:0] noise;
        logic [63:0] m;
        logic [63:0] v;
        noise = {$urandom, $urandom};
        m = zone_summary_predictor::width_mask(t);
        case ($urandom_range(0, 11))
            0: v = zone_summary_predictor::top_value(t);
            1: v = zone_summary_predictor::bottom_value(t);
            2: v = 64'd0;
            3:
            begin
                if (t == VT_FLOAT32)
                    v = 64'h8000_0000;
                else if (t == VT_FLOAT64)
                    v = 64'h8000_0000_0000_0000;
                else
                    v = 64'hFFFF_FFFF_FFFF_FFFF;
            end
            4:
            begin
                if (t == VT_FLOAT32)
                    v = {32'd0, noise[40], 8'hFF, 23'd0};
                else if (t == VT_FLOAT64)
                    v = {noise[40], 11'h7FF, 52'd0};
                else
                    v = noise & 64'hF;
            end
            5:
            begin
                if (t == VT_FLOAT32)
                    v = {32'd0, noise[40], 8'hFF, noise[22:1], 1'b1};
                else if (t == VT_FLOAT64)
                    v = {noise[63], 11'h7FF, noise[51:1], 1'b1};
                else
                    v = noise;
            end
            default: return noise;
        endcase
        return (v & m) | (noise & ~m);
    endfunction

    initial
    begin
        int                    sent;
        int                    n;
        int                    phase;
        int                    action;
        logic [CFG_DATA_W-1:0] setting;

        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: int64, zones of 1024
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_value(64'd5, 1'b0);
        send_value(64'h8000_0000_0000_0000, 1'b1);
        drain();

        // int8 extremes with junk in the unused bits, one value per zone
        write_register(CFG_VALUE_TYPE, {2'b11, VT_INT8});
        write_register(CFG_ZONE_LOG2, 5'd0);
        send_value(64'hFFFF_FFFF_FFFF_FF7F, 1'b0);
        send_value(64'h0000_0000_0000_0080, 1'b0);
        send_value(64'h0000_0000_0000_0000, 1'b0);
        send_value(64'h1234_5678_9ABC_DEFF, 1'b1);
        drain();

        // float32 pairs: only NaNs, signed zeros, only -inf, then +inf
        write_register(CFG_VALUE_TYPE, {2'b00, VT_FLOAT32});
        write_register(CFG_ZONE_LOG2, 5'd1);
        send_value(64'hA5A5_0000_7FC0_0000, 1'b0);
        send_value(64'h0000_0000_FF80_0001, 1'b0);
        send_value(64'h0000_0000_8000_0000, 1'b0);
        send_value(64'h0000_0000_0000_0000, 1'b0);
        send_value(64'h0000_0000_FF80_0000, 1'b0);
        send_value(64'hFFFF_FFFF_FF80_0000, 1'b0);
        send_value(64'h0000_0000_7F80_0000, 1'b0);
        send_value(64'h0000_0000_3F80_0000, 1'b1);
        drain();

        // Ignored register index, then float64 specials
        write_register(CFG_INDEX_W'(LAST_INDEX), 5'h1F);
        write_register(CFG_VALUE_TYPE, {2'b00, VT_FLOAT64});
        write_register(CFG_ZONE_LOG2, 5'd1);
        send_value(64'h7FF8_0000_0000_0000, 1'b0);
        send_value(64'hFFF0_0000_0000_0000, 1'b0);
        send_value(64'h7FF0_0000_0000_0000, 1'b0);
        send_value(64'h8000_0000_0000_0000, 1'b1);
        drain();

        // Undefined type code reads as int64
        write_register(CFG_VALUE_TYPE, {2'b00, UNDEFINED_TYPE_CODE});
        write_register(CFG_ZONE_LOG2, 5'd0);
        send_value(64'h8000_0000_0000_0000, 1'b0);
        send_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_value(64'h0000_0000_0000_0000, 1'b1);
        drain();

        // uint64 extremes in one zone of four
        write_register(CFG_VALUE_TYPE, {2'b00, VT_UINT64});
        write_register(CFG_ZONE_LOG2, 5'd2);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_value(64'h0000_0000_0000_0000, 1'b0);
        send_value(64'h0000_0000_0000_0001, 1'b0);
        send_value(64'h8000_0000_0000_0000, 1'b1);
        drain();

        // Oversized zone exponent: a column shorter than the saturated zone
        write_register(CFG_ZONE_LOG2, 5'd31);
        for (int i = 0; i < LONG_RUN_ITEMS; i++)
            send_value(random_value(predictor.kind()), i == LONG_RUN_ITEMS - 1);
        drain();

        // Random phases with random settings between them
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            action = $urandom_range(0, 9);
            if (action == 0)
                write_register(CFG_INDEX_W'($urandom_range(FIRST_UNUSED_INDEX, LAST_INDEX)),
                               CFG_DATA_W'($urandom));
            else if (action != 1)
            begin
                if (action != 3)
                    write_register(CFG_VALUE_TYPE, CFG_DATA_W'($urandom));
                if (action != 2)
                begin
                    case ($urandom_range(0, 9))
                        7:       setting = CFG_DATA_W'($urandom_range(4, 8));
                        8, 9:    setting = CFG_DATA_W'($urandom_range(16, 31));
                        default: setting = CFG_DATA_W'($urandom_range(0, 3));
                    endcase
                    write_register(CFG_ZONE_LOG2, setting);
                end
            end

            // Phase 2 stalls the result side with a summary per word to fill the block
            if (phase == 2)
            begin
                write_register(CFG_ZONE_LOG2, 5'd0);
                ready_hold_left = READY_HOLD_CYCLES;
            end
            idle_pct = (phase == 4 || phase == 5) ? 0 : IDLE_PERCENT;

            n = $urandom_range(40, 120);
            for (int i = 0; i < n; i++)
                send_value(random_value(predictor.kind()), $urandom_range(0, 14) == 0);
            sent += n;
            phase++;
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (predictor.mismatches == 0)
            $display("** zone_min_max_summarizer: PASSED **");
        else
            $display("** zone_min_max_summarizer: FAILED **");
        $finish;
    end

endmodule
